// ===== hw/rtl/dcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared widths, event record, register indexes and the control bundles
// that pass between the selector's store, matcher and sequencer.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int ADDR_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

    localparam int ENERGY_W = 16;
    localparam int TIME_W   = 48;
    localparam int POS_W    = 16;
    localparam int TCUT_W   = 24;
    localparam int DCUT_W   = 16;
    localparam int MATCH_W  = 5;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAYED_LOW  = 3'd0,
        REG_DELAYED_HIGH = 3'd1,
        REG_PROMPT_LOW   = 3'd2,
        REG_PROMPT_HIGH  = 3'd3,
        REG_TIME_CUT     = 3'd4,
        REG_DIST_CUT     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [ENERGY_W-1:0] energy;
        logic        [TIME_W-1:0]   time_ns;
        logic signed [POS_W-1:0]    x;
        logic signed [POS_W-1:0]    y;
        logic signed [POS_W-1:0]    z;
    } t_event;

    // Read request from the sequencer to the store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // Registered read beat from the store
    typedef struct packed {
        logic   valid;
        t_event data;
    } t_rd_beat;

    // Matcher result back to the sequencer
    typedef struct packed {
        logic valid;
        logic hit;
        logic busy;
    } t_match_res;

    // Prompt-side cuts seen by the matcher
    typedef struct packed {
        logic [ENERGY_W-1:0] prompt_low;
        logic [ENERGY_W-1:0] prompt_high;
        logic [TCUT_W-1:0]   time_cut;
        logic [DCUT_W-1:0]   dist_cut;
    } t_cuts;

endpackage

// ===== hw/rtl/delayed_coincidence_selector_unit.sv =====
`timescale 1ns / 1ps
// When the event is in the delayed window and the history is not empty, the
// sequencer reads every stored event (at most HISTORY_DEPTH) through the
// matcher, one history read per cycle, then drains the matcher; otherwise it
// goes straight to storing the event. The next beat is taken once the history
// write of the previous one is done. Reset clears the cut registers to their
// defaults, the fill level, write slot and both counters at once.
// ----------------------------------------------------------------------------
// delayed_coincidence_selector_unit
// Prompt/delayed coincidence selector: for an event in the delayed window,
// scans the event history memory one entry a cycle through the matcher, counts
// prompt partners, then stores the new event and reports the counters.
// ----------------------------------------------------------------------------
module delayed_coincidence_selector_unit import dcs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // event input
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ENERGY_W-1:0]        i_energy_kev,
    input  logic [TIME_W-1:0]          i_time_ns,
    input  logic signed [POS_W-1:0]    i_vertex_x,
    input  logic signed [POS_W-1:0]    i_vertex_y,
    input  logic signed [POS_W-1:0]    i_vertex_z,
    // result output
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_selected,
    output logic [MATCH_W-1:0]         o_prompt_matches,
    output logic [COUNT_W-1:0]         o_events_seen,
    output logic [COUNT_W-1:0]         o_events_chosen,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state r_state;

    logic [ENERGY_W-1:0] r_delayed_low, r_delayed_high;
    logic [ENERGY_W-1:0] r_prompt_low, r_prompt_high;
    logic [TCUT_W-1:0]   r_time_cut;
    logic [DCUT_W-1:0]   r_dist_cut;

    t_event              r_evt;
    logic                r_scan;
    logic [FILL_W-1:0]   r_idx;
    logic [FILL_W-1:0]   r_fill;
    logic [ADDR_W-1:0]   r_slot;
    logic [FILL_W-1:0]   r_matches;
    logic [COUNT_W-1:0]  r_processed;
    logic [COUNT_W-1:0]  r_chosen;

    logic                r_out_valid;
    logic                r_out_sel;
    logic [MATCH_W-1:0]  r_out_matches;
    logic [COUNT_W-1:0]  r_out_seen;
    logic [COUNT_W-1:0]  r_out_chosen;

    t_rd_req             rd_req;
    t_rd_beat            rd_beat;
    t_match_res          mres;
    t_cuts               cuts;
    logic                in_beat;
    logic                out_free;
    logic                wr_en;
    logic                in_window;
    logic                sel_now;
    logic [FILL_W+MATCH_W-1:0] match_ext;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign wr_en       = (r_state == ST_FINISH) && out_free;
    assign in_window   = (i_energy_kev >= r_delayed_low) && (i_energy_kev <= r_delayed_high);
    assign sel_now     = r_scan && (r_matches != '0);
    assign match_ext   = (FILL_W + MATCH_W)'(r_matches);

    assign rd_req.en   = (r_state == ST_SCAN);
    assign rd_req.addr = r_idx[ADDR_W-1:0];

    assign cuts.prompt_low  = r_prompt_low;
    assign cuts.prompt_high = r_prompt_high;
    assign cuts.time_cut    = r_time_cut;
    assign cuts.dist_cut    = r_dist_cut;

    dcs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_evt),
        .i_rd      (rd_req),
        .o_rd      (rd_beat)
    );

    dcs_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_beat),
        .i_evt   (r_evt),
        .i_cuts  (cuts),
        .o_res   (mres)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delayed_low  <= ENERGY_W'(1900);
            r_delayed_high <= ENERGY_W'(2500);
            r_prompt_low   <= ENERGY_W'(700);
            r_prompt_high  <= ENERGY_W'(12000);
            r_time_cut     <= TCUT_W'(1000000);
            r_dist_cut     <= DCUT_W'(1500);
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_DELAYED_LOW:  r_delayed_low  <= i_cfg_data[ENERGY_W-1:0];
                REG_DELAYED_HIGH: r_delayed_high <= i_cfg_data[ENERGY_W-1:0];
                REG_PROMPT_LOW:   r_prompt_low   <= i_cfg_data[ENERGY_W-1:0];
                REG_PROMPT_HIGH:  r_prompt_high  <= i_cfg_data[ENERGY_W-1:0];
                REG_TIME_CUT:     r_time_cut     <= i_cfg_data[TCUT_W-1:0];
                REG_DIST_CUT:     r_dist_cut     <= i_cfg_data[DCUT_W-1:0];
                default: ;
            endcase
        end
    end

    // event payload, held through the scan
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_evt.energy  <= i_energy_kev;
            r_evt.time_ns <= i_time_ns;
            r_evt.x       <= i_vertex_x;
            r_evt.y       <= i_vertex_y;
            r_evt.z       <= i_vertex_z;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_scan        <= 1'b0;
            r_idx         <= '0;
            r_fill        <= '0;
            r_slot        <= '0;
            r_matches     <= '0;
            r_processed   <= '0;
            r_chosen      <= '0;
            r_out_valid   <= 1'b0;
            r_out_sel     <= 1'b0;
            r_out_matches <= '0;
            r_out_seen    <= '0;
            r_out_chosen  <= '0;
        end else begin
            if (r_out_valid && i_ready && !wr_en) begin
                r_out_valid <= 1'b0;
            end
            if (mres.valid && mres.hit) begin
                r_matches <= r_matches + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_scan    <= in_window && (r_fill != '0);
                        r_idx     <= '0;
                        r_matches <= '0;
                        r_state   <= (in_window && (r_fill != '0)) ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    // advance one history entry a cycle
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_fill - 1'b1) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!mres.busy) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // store the event and publish once the output register is free
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_sel     <= sel_now;
                        r_out_matches <= match_ext[MATCH_W-1:0];
                        r_out_seen    <= r_processed + 1'b1;
                        r_out_chosen  <= r_chosen + COUNT_W'(sel_now);
                        r_processed   <= r_processed + 1'b1;
                        r_chosen      <= r_chosen + COUNT_W'(sel_now);
                        r_slot        <= (r_slot == ADDR_W'(HISTORY_DEPTH - 1)) ?
                                         '0 : r_slot + 1'b1;
                        if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_selected       = r_out_sel;
    assign o_prompt_matches = r_out_matches;
    assign o_events_seen    = r_out_seen;
    assign o_events_chosen  = r_out_chosen;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("fill level above history depth");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matches <= r_fill)
        else $error("more matches than stored events");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !mres.busy)
        else $error("matcher busy while taking a new event");

    a_seen_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_events_seen == r_processed))
        else $error("reported count out of step with counter");

    a_sel_has_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && o_selected |-> (o_events_chosen == r_chosen) &&
        (r_chosen != $past(r_chosen)))
        else $error("selected event did not advance the chosen counter");

endmodule

// ===== hw/rtl/dcs_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_store
// Event history memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dcs_store import dcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_event            i_wr_data,
    input  t_rd_req           i_rd,
    output t_rd_beat          o_rd
);

    t_event r_mem [HISTORY_DEPTH];
    t_event r_rd_data;
    logic   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd.en;
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.data  = r_rd_data;

endmodule

// ===== hw/rtl/dcs_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_match
// Three-stage prompt test of one stored event against the current event:
// window and time checks with vertex differences, then squares, then the
// distance sum against the squared cut.
// ----------------------------------------------------------------------------
module dcs_match import dcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rd_beat   i_rd,
    input  t_event     i_evt,
    input  t_cuts      i_cuts,
    output t_match_res o_res
);

    localparam int SQ_W  = 2 * POS_W;
    localparam int SUM_W = SQ_W + 2;

    // stage 1
    logic              r_v1;
    logic              r_ok1;
    logic [POS_W-1:0]  r_dx, r_dy, r_dz;
    // stage 2
    logic              r_v2;
    logic              r_ok2;
    logic [SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [2*DCUT_W-1:0] r_cut2;
    // stage 3
    logic              r_v3;
    logic              r_hit;

    logic              e_ok, t_ok;
    logic [TIME_W-1:0] t_diff;
    logic [POS_W-1:0]  dx, dy, dz;
    logic [SUM_W-1:0]  d2;

    function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                  logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic        [POS_W:0] m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        m = d[POS_W] ? (~d + 1'b1) : d;
        return m[POS_W-1:0];
    endfunction

    always_comb begin
        e_ok   = (i_rd.data.energy >= i_cuts.prompt_low) &&
                 (i_rd.data.energy <= i_cuts.prompt_high);
        t_diff = i_evt.time_ns - i_rd.data.time_ns;
        t_ok   = (i_evt.time_ns >= i_rd.data.time_ns) &&
                 (t_diff <= TIME_W'(i_cuts.time_cut));
        dx     = abs_diff(i_evt.x, i_rd.data.x);
        dy     = abs_diff(i_evt.y, i_rd.data.y);
        dz     = abs_diff(i_evt.z, i_rd.data.z);
        d2     = SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
    end

    always_ff @(posedge i_clk) begin
        r_ok1  <= e_ok && t_ok;
        r_dx   <= dx;
        r_dy   <= dy;
        r_dz   <= dz;
        r_ok2  <= r_ok1;
        r_sx   <= r_dx * r_dx;
        r_sy   <= r_dy * r_dy;
        r_sz   <= r_dz * r_dz;
        r_cut2 <= i_cuts.dist_cut * i_cuts.dist_cut;
        r_hit  <= r_ok2 && (d2 <= SUM_W'(r_cut2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_rd.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res.valid = r_v3;
    assign o_res.hit   = r_hit;
    assign o_res.busy  = i_rd.valid | r_v1 | r_v2 | r_v3;

endmodule
